// ===== rtl/hsa_pkg.sv =====
package hsa_pkg;

   // Table geometry
   localparam int SLOTS    = 64;
   localparam int FIRST_ID = 1;

   // Field widths
   localparam int FUNC_W   = 2;
   localparam int SLOT_W   = 6;
   localparam int ID_W     = 27;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // Internal widths
   localparam int SLOT_AW  = $clog2(SLOTS);
   localparam int LIVE_W   = $clog2(SLOTS + 1);

   // Stream packing
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   localparam logic [ID_W-1:0] ID_LIMIT_RESET = ID_W'(9999);
   localparam logic [ID_W-1:0] LAST_ID_RESET  = ID_W'(FIRST_ID - 1);

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_IN_USE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_MISMATCH   = 2'd3;

   typedef struct packed {
      logic               found;
      logic [SLOT_AW-1:0] idx;
   } free_slot_type;

endpackage

// ===== rtl/hsa_free_finder.sv =====
module hsa_free_finder (
   input  logic [hsa_pkg::SLOTS-1:0] in_use,
   output hsa_pkg::free_slot_type    result
);

   // Lowest clear bit wins: scan down so the last hit is the lowest index
   always_comb begin
      result = '0;
      for (int i = hsa_pkg::SLOTS - 1; i >= 0; i--) begin
         if (!in_use[i]) begin
            result.found = 1'b1;
            result.idx   = hsa_pkg::SLOT_AW'(i);
         end
      end
   end

endmodule

// ===== rtl/handle_slot_allocator.sv =====
// Handle slot allocator: a 64-slot table of generational handles. Each request
// (allocate, free, lookup, flush) is captured in an input register together with
// the stamp read from the slot stamp memory, resolved against the in-use flops by
// a priority encoder, and presented in the response register.
// One request is taken every cycle when the response side keeps up. The user
// must write the id limit through the csr port only while no request is in
// flight; the block itself does not enforce this.
module handle_slot_allocator (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              csr_wr_en,
   input  logic [hsa_pkg::ID_W-1:0]          csr_wr_data,  // id_limit

   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [hsa_pkg::REQ_DATA_W-1:0]    req_tdata,    // slot, entry_id, zero fill
   input  logic [hsa_pkg::FUNC_W-1:0]        req_tuser,    // func

   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [hsa_pkg::RSP_DATA_W-1:0]    rsp_tdata,    // slot_out, id_out, live_count_out
   output logic [hsa_pkg::STATUS_W-1:0]      rsp_tuser     // status
);

   localparam int ID_W    = hsa_pkg::ID_W;
   localparam int SLOT_W  = hsa_pkg::SLOT_W;
   localparam int SLOT_AW = hsa_pkg::SLOT_AW;
   localparam int LIVE_W  = hsa_pkg::LIVE_W;
   localparam int SLOTS   = hsa_pkg::SLOTS;

   logic [ID_W-1:0]             id_limit_ff;

   logic                        req_valid_ff;
   logic [hsa_pkg::FUNC_W-1:0]  req_func_ff;
   logic [SLOT_W-1:0]           req_slot_ff;
   logic [ID_W-1:0]             req_id_ff;

   logic [ID_W-1:0]             stamp_mem [SLOTS];
   logic [ID_W-1:0]             rd_stamp_ff;
   logic                        fwd_ff;
   logic [ID_W-1:0]             fwd_stamp_ff;

   logic [SLOTS-1:0]            in_use_ff, in_use_in;
   logic [ID_W-1:0]             last_id_ff, last_id_in;
   logic [LIVE_W-1:0]           live_ff, live_in;

   logic                        rsp_valid_ff;
   logic [SLOT_W-1:0]           rsp_slot_ff, rsp_slot_in;
   logic [ID_W-1:0]             rsp_id_ff, rsp_id_in;
   logic [hsa_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [hsa_pkg::COUNT_W-1:0] rsp_live_ff;

   hsa_pkg::free_slot_type      free_slot;

   logic                        advance;
   logic                        req_accept;
   logic [SLOT_AW-1:0]          rd_addr;
   logic [SLOT_AW-1:0]          cur_addr;
   logic                        mem_we;
   logic [ID_W-1:0]             new_id;
   logic [ID_W-1:0]             cur_stamp;
   logic                        slot_live;

   hsa_free_finder u_free_finder (
      .in_use (in_use_ff),
      .result (free_slot)
   );

   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;
   assign rd_addr    = SLOT_AW'(req_tdata[SLOT_W-1:0]);
   assign cur_addr   = SLOT_AW'(req_slot_ff);

   assign new_id    = (last_id_ff >= id_limit_ff) ? '0 : last_id_ff + 1'b1;
   assign mem_we    = advance && (req_func_ff == hsa_pkg::FUNC_ALLOC) && free_slot.found;
   assign cur_stamp = fwd_ff ? fwd_stamp_ff : rd_stamp_ff;
   assign slot_live = (32'(req_slot_ff) < 32'(SLOTS)) && in_use_ff[cur_addr];

   always_ff @(posedge clock) begin
      if (reset) begin
         id_limit_ff <= hsa_pkg::ID_LIMIT_RESET;
      end else if (csr_wr_en) begin
         id_limit_ff <= csr_wr_data;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_func_ff <= req_tuser;
         req_slot_ff <= req_tdata[SLOT_W-1:0];
         req_id_ff   <= req_tdata[SLOT_W+ID_W-1:SLOT_W];
      end
   end

   // Stamp memory; forward a stamp written in the same cycle as the read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stamp_mem[free_slot.idx] <= new_id;
      end
      if (req_accept) begin
         rd_stamp_ff  <= stamp_mem[rd_addr];
         fwd_stamp_ff <= new_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (req_accept) begin
         fwd_ff <= mem_we && (free_slot.idx == rd_addr);
      end
   end

   always_comb begin
      in_use_in     = in_use_ff;
      last_id_in    = last_id_ff;
      live_in       = live_ff;
      rsp_slot_in   = '0;
      rsp_id_in     = '0;
      rsp_status_in = hsa_pkg::ST_OK;
      unique case (req_func_ff)
         hsa_pkg::FUNC_ALLOC: begin
            if (free_slot.found) begin
               in_use_in[free_slot.idx] = 1'b1;
               last_id_in  = new_id;
               live_in     = live_ff + 1'b1;
               rsp_slot_in = SLOT_W'(free_slot.idx);
               rsp_id_in   = new_id;
            end else begin
               rsp_status_in = hsa_pkg::ST_FULL;
            end
         end
         hsa_pkg::FUNC_FREE: begin
            if (!slot_live) begin
               rsp_status_in = hsa_pkg::ST_NOT_IN_USE;
            end else begin
               // Clear even on a mismatch
               in_use_in[cur_addr] = 1'b0;
               if (live_ff != '0) begin
                  live_in = live_ff - 1'b1;
               end
               rsp_slot_in   = req_slot_ff;
               rsp_id_in     = cur_stamp;
               rsp_status_in = (cur_stamp == req_id_ff) ? hsa_pkg::ST_OK
                                                        : hsa_pkg::ST_MISMATCH;
            end
         end
         hsa_pkg::FUNC_LOOKUP: begin
            if (!slot_live) begin
               rsp_status_in = hsa_pkg::ST_NOT_IN_USE;
            end else if (cur_stamp != req_id_ff) begin
               rsp_status_in = hsa_pkg::ST_MISMATCH;
            end else begin
               rsp_slot_in = req_slot_ff;
               rsp_id_in   = cur_stamp;
            end
         end
         hsa_pkg::FUNC_FLUSH: begin
            in_use_in = '0;
            live_in   = '0;
         end
         default: begin
            rsp_status_in = hsa_pkg::ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff  <= '0;
         last_id_ff <= hsa_pkg::LAST_ID_RESET;
         live_ff    <= '0;
      end else if (advance) begin
         in_use_ff  <= in_use_in;
         last_id_ff <= last_id_in;
         live_ff    <= live_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_slot_ff   <= rsp_slot_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_status_ff <= rsp_status_in;
         rsp_live_ff   <= hsa_pkg::COUNT_W'(live_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_live_ff, rsp_id_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_status_ff;

   // Live count tracks the in-use bits
   a_live_matches_bits: assert property (@(posedge clock) disable iff (reset)
      live_ff == LIVE_W'($countones(in_use_ff)))
      else $error("live count differs from in-use population");

   a_stall_only_on_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !req_tready) |-> (rsp_valid_ff && !rsp_tready))
      else $error("input stage stalled without response backpressure");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_valid_ff)
      else $error("accepted transaction not held in input register");

   a_full_means_all_used: assert property (@(posedge clock) disable iff (reset)
      (advance && (req_func_ff == hsa_pkg::FUNC_ALLOC) && !free_slot.found)
      |-> (live_ff == LIVE_W'(SLOTS)))
      else $error("table full reported with free slots left");

   a_alloc_sets_bit: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> in_use_ff[$past(free_slot.idx)])
      else $error("allocated slot not marked in use");

endmodule
